// ===== rtl/strp_pkg.sv =====
// ----------------------------------------------------------------------------
// strp_pkg - shared types and constants of the stepper ramp unit
// command and status groups between controller and datapath, fixed widths
// ----------------------------------------------------------------------------
package strp_pkg;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_DELAY  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_SCALE  = 2'd2;

    localparam int CFG_W      = 16;  // configuration register width
    localparam int POS_W      = 32;  // position width
    localparam int DELAY_W    = 32;  // delay register width
    localparam int DIVIDEND_W = DELAY_W + 1;  // twice the delay
    localparam int IVL_W      = 16;  // reported interval width
    localparam int PROD_W     = DELAY_W + CFG_W;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch an accepted input beat
        logic start;     // apply a start command
        logic set_done;  // tick with no steps left
        logic plan;      // launch the divider for a step
        logic commit;    // apply a step
        logic emit;      // load the result register
    } strp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_op;
        logic has_step;
        logic need_div;
        logic div_done;
    } strp_status_t;

endpackage

// ===== rtl/strp_divider.sv =====
// ----------------------------------------------------------------------------
// strp_divider - restoring divider, one quotient bit per cycle
// divides twice the delay by the odd ramp denominator
// ----------------------------------------------------------------------------
module strp_divider #(
    parameter int DEN_W = 34
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [strp_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [DEN_W-1:0]                divisor,
    output logic                            busy,
    output logic [strp_pkg::DIVIDEND_W-1:0] quotient
);
    import strp_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   trial_sub;
    logic [DEN_W-1:0] rem_next;

    assign trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign rem_next  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            rem_reg  <= '0;
            den_reg  <= divisor;
            dvd_reg  <= dividend;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/strp_datapath.sv =====
// ----------------------------------------------------------------------------
// strp_datapath - ramp state, step arithmetic and result register
// holds configuration, position and delay; runs the serial divider
// ----------------------------------------------------------------------------
module strp_datapath #(
    parameter int COUNT_BITS      = 32,
    parameter int DELAY_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  strp_pkg::strp_cmd_t               cmd,
    output strp_pkg::strp_status_t            status,
    input  logic                              cfg_valid,
    input  logic [strp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [strp_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_cmd,
    input  logic signed [strp_pkg::POS_W-1:0] in_target,
    output logic                              out_step_pulse,
    output logic                              out_dir_level,
    output logic [strp_pkg::IVL_W-1:0]        out_interval,
    output logic                              out_move_done,
    output logic signed [strp_pkg::POS_W-1:0] out_position
);
    import strp_pkg::*;

    localparam int CW    = COUNT_BITS;
    localparam int DEN_W = CW + 2;
    localparam int WIDE  = 48;
    localparam int SHIFT = DELAY_FRAC_BITS + 8;

    logic [CFG_W-1:0]   start_delay_reg;
    logic [CFG_W-1:0]   min_interval_reg;
    logic [CFG_W-1:0]   speed_scale_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      sdone_reg;
    logic [CW-1:0]      ridx_reg;
    logic [CW-1:0]      rlen_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               dirn_reg;
    logic               doneflag_reg;
    logic               pulse_reg;
    logic               cmd_reg;
    logic [POS_W-1:0]   target_reg;

    logic [IVL_W-1:0]   ivl_reg;
    logic [POS_W-1:0]   opos_reg;
    logic               opulse_reg;
    logic               odir_reg;
    logic               odone_reg;

    // step decisions
    logic [CW-1:0]      sd1;
    logic [CW-1:0]      ridx_inc;
    logic [CW-1:0]      ridx_dec;
    logic               second_half;
    logic               ridx_nz;
    logic               can_down;
    logic [DEN_W-1:0]   den;
    logic               div_busy;
    logic [DIVIDEND_W-1:0] quo;

    // ramp up / down
    logic [DELAY_W+1:0] up_diff;
    logic [DELAY_W+1:0] dn_sum;
    logic [WIDE-1:0]    minq48;
    logic [WIDE-1:0]    sdq48;
    logic [DELAY_W-1:0] minq_sat;
    logic [DELAY_W-1:0] sdq_sat;
    logic [DELAY_W-1:0] dn_sat;

    // start distance
    logic [POS_W:0]     span;
    logic [POS_W:0]     mag;
    logic [POS_W:0]     cmask;
    logic [CW-1:0]      total_new;

    // result interval
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_sh;

    assign sd1         = sdone_reg + CW'(1);
    assign ridx_inc    = ridx_reg + CW'(1);
    assign ridx_dec    = ridx_reg - CW'(1);
    assign second_half = sd1 > (total_reg >> 1);
    assign ridx_nz     = ridx_reg != '0;
    assign can_down    = ridx_nz && ((rlen_reg == '0) || (ridx_reg < rlen_reg));
    // 4n+1 on the way up, 4n-1 = 4(n-1)+3 on the way down
    assign den         = second_half ? {ridx_dec, 2'b11} : {ridx_inc, 2'b01};

    assign status.start_op = (cmd_reg == CMD_START);
    assign status.has_step = sdone_reg < total_reg;
    assign status.need_div = second_half ? can_down : 1'b1;
    assign status.div_done = !div_busy;

    strp_divider #(
        .DEN_W(DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.plan),
        .dividend ({delay_reg, 1'b0}),
        .divisor  (den),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign up_diff  = {2'b00, delay_reg} - {1'b0, quo};
    assign dn_sum   = {2'b00, delay_reg} + {1'b0, quo};
    assign dn_sat   = (dn_sum[DELAY_W+1:DELAY_W] != 2'b00) ? '1 : dn_sum[DELAY_W-1:0];
    assign minq48   = WIDE'({min_interval_reg, {DELAY_FRAC_BITS{1'b0}}});
    assign sdq48    = WIDE'({start_delay_reg, {DELAY_FRAC_BITS{1'b0}}});
    assign minq_sat = (minq48 > WIDE'({DELAY_W{1'b1}})) ? '1 : minq48[DELAY_W-1:0];
    assign sdq_sat  = (sdq48 > WIDE'({DELAY_W{1'b1}})) ? '1 : sdq48[DELAY_W-1:0];

    assign span      = {target_reg[POS_W-1], target_reg} - {pos_reg[POS_W-1], pos_reg};
    assign mag       = span[POS_W] ? (~span + (POS_W+1)'(1)) : span;
    assign cmask     = (POS_W+1)'({CW{1'b1}});
    assign total_new = (mag > cmask) ? {CW{1'b1}} : mag[CW-1:0];

    assign prod    = PROD_W'(delay_reg) * PROD_W'(speed_scale_reg);
    assign prod_sh = prod >> SHIFT;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg  <= CFG_W'(400);
            min_interval_reg <= CFG_W'(10);
            speed_scale_reg  <= CFG_W'(256);
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_START_DELAY:  start_delay_reg  <= cfg_data;
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                CFG_SPEED_SCALE:  speed_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= in_cmd;
            target_reg <= in_target;
        end
    end

    // ramp state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            total_reg    <= '0;
            sdone_reg    <= '0;
            ridx_reg     <= '0;
            rlen_reg     <= '0;
            delay_reg    <= '0;
            dirn_reg     <= 1'b0;
            doneflag_reg <= 1'b1;
            pulse_reg    <= 1'b0;
        end else if (cmd.start) begin
            dirn_reg     <= span[POS_W];
            total_reg    <= total_new;
            sdone_reg    <= '0;
            ridx_reg     <= '0;
            rlen_reg     <= '0;
            delay_reg    <= sdq_sat;
            doneflag_reg <= 1'b0;
            pulse_reg    <= 1'b0;
        end else if (cmd.set_done) begin
            doneflag_reg <= 1'b1;
            pulse_reg    <= 1'b0;
        end else if (cmd.commit) begin
            pulse_reg <= 1'b1;
            sdone_reg <= sd1;
            pos_reg   <= dirn_reg ? pos_reg - POS_W'(1) : pos_reg + POS_W'(1);
            if (second_half) begin
                if (can_down) begin
                    delay_reg <= dn_sat;
                end
                if (ridx_nz) begin
                    ridx_reg <= ridx_dec;
                end
            end else begin
                ridx_reg <= ridx_inc;
                if (up_diff[DELAY_W+1]) begin
                    // quotient exceeded the delay: wraps huge, saturates
                    delay_reg <= '1;
                end else if (WIDE'(up_diff[DELAY_W-1:0]) <= minq48) begin
                    delay_reg <= minq_sat;
                    if (rlen_reg == '0) begin
                        rlen_reg <= sd1;
                    end
                end else begin
                    delay_reg <= up_diff[DELAY_W-1:0];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            opulse_reg <= pulse_reg;
            odir_reg   <= dirn_reg;
            odone_reg  <= doneflag_reg;
            opos_reg   <= pos_reg;
            ivl_reg    <= (prod_sh > PROD_W'({IVL_W{1'b1}})) ? '1 : prod_sh[IVL_W-1:0];
        end
    end

    assign out_step_pulse = opulse_reg;
    assign out_dir_level  = odir_reg;
    assign out_interval   = ivl_reg;
    assign out_move_done  = odone_reg;
    assign out_position   = opos_reg;

endmodule

// ===== rtl/strp_ctrl.sv =====
// ----------------------------------------------------------------------------
// strp_ctrl - sequencing of one input beat through the datapath
// decode, optional divide, commit and hand-off to the result register
// ----------------------------------------------------------------------------
module strp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output strp_pkg::strp_cmd_t    cmd,
    input  strp_pkg::strp_status_t status
);
    import strp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_valid;
            end
            S_DECODE: begin
                if (status.start_op) begin
                    cmd.start = 1'b1;
                end else if (!status.has_step) begin
                    cmd.set_done = 1'b1;
                end else if (status.need_div) begin
                    cmd.plan = 1'b1;
                end else begin
                    cmd.commit = 1'b1;
                end
            end
            S_DIV: begin
                cmd.commit = status.div_done;
            end
            S_EMIT: begin
                cmd.emit = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) state_reg <= S_DECODE;
                end
                S_DECODE: begin
                    state_reg <= cmd.plan ? S_DIV : S_EMIT;
                end
                S_DIV: begin
                    if (status.div_done) state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (cmd.emit) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/stepper_trapezoid_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit - trapezoidal step timing for one axis
// constant-acceleration ramp with a serial divider per step
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one beat is a command; s_cmd start (with s_target, an
//   absolute position) or timer tick. every beat gives exactly one result
//   beat on m_*: step flag, direction, next timer reload, done, position.
//   cfg_*: register writes (start delay, min interval, speed scale), always
//   ready, to be written only while no beat is in flight.
// sequencing
//   start, or a tick with no steps left: decode, then the result register
//   is loaded; the next beat is taken once the controller is idle again.
//   tick that steps: a bit-serial divide of twice the delay by the ramp
//   denominator, between decode and emit, sets the pace; no new beat is
//   taken until its result is loaded. a step on the unwinding part of the
//   ramp with no division left to do takes the short path.
// reset
//   aresetn low clears position, counters and delay, sets done and reloads
//   the registers with their defaults (400, 10, 1.0).
// stall
//   the result sits in an output register; one more beat is accepted and
//   worked on, then held until m_ready takes the waiting result.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_unit #(
    parameter int COUNT_BITS      = 32,
    parameter int DELAY_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [strp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [strp_pkg::CFG_W-1:0]        cfg_data,
    // command beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic signed [strp_pkg::POS_W-1:0] s_target,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_step_pulse,
    output logic                              m_dir_level,
    output logic [strp_pkg::IVL_W-1:0]        m_interval,
    output logic                              m_move_done,
    output logic signed [strp_pkg::POS_W-1:0] m_position
);
    import strp_pkg::*;

    strp_cmd_t    cmd;
    strp_status_t status;

    // registers are plain flops, a write always lands
    assign cfg_ready = 1'b1;

    strp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    strp_datapath #(
        .COUNT_BITS      (COUNT_BITS),
        .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .in_cmd         (s_cmd),
        .in_target      (s_target),
        .out_step_pulse (m_step_pulse),
        .out_dir_level  (m_dir_level),
        .out_interval   (m_interval),
        .out_move_done  (m_move_done),
        .out_position   (m_position)
    );

endmodule

// ===== rtl/strp_checker.sv =====
// ----------------------------------------------------------------------------
// strp_checker - port-level checks of the stepper ramp unit
// bound to the top level
// ----------------------------------------------------------------------------
module strp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_cmd,
    input logic signed [strp_pkg::POS_W-1:0] s_target,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_step_pulse,
    input logic                              m_dir_level,
    input logic [strp_pkg::IVL_W-1:0]        m_interval,
    input logic                              m_move_done,
    input logic signed [strp_pkg::POS_W-1:0] m_position
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_dir_level)
            && $stable(m_interval) && $stable(m_step_pulse) && $stable(m_move_done))
        else $error("result beat changed while stalled");

    // a waiting command beat keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cmd) && $stable(s_target))
        else $error("command beat changed while waiting");

    // a step is never reported on a finished move
    a_step_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_step_pulse && m_move_done))
        else $error("step issued with move done");

    // one beat in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stepper_trapezoid_ramp_unit strp_checker u_strp_checker (.*);
